[rtl/c2rs_pkg.sv]
// c2rs_pkg: shared widths, constants and controller/datapath signal groups
// for the column to row span converter. No dependencies.

package c2rs_pkg;

  localparam int COL_W     = 9;  // column index and span start/end
  localparam int EDGE_W    = 8;  // top/bottom row fields of an input transaction
  localparam int SPAN_ROW_W = 6; // span_row output field

  localparam logic [EDGE_W-1:0] EMPTY_MARK = 8'hff;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a new input transaction
    logic close_step; // read start of next closed row, advance top or bottom
    logic emit;       // move pending span into the output register
    logic open_top;   // record start column for next newly covered top row
    logic open_bot;   // record start column for next newly covered bottom row
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic any_close;     // rows remain to be closed
    logic open_top_more; // top rows remain to be opened
    logic open_bot_more; // bottom rows remain to be opened
    logic out_free;      // output register can take a span this cycle
  } status_t;

endpackage

[rtl/column_to_row_span_converter.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | column, prev_top, prev_bottom, cur_top, cur_bottom
// out     | output    | out_valid / out_stall | span_row, span_start, span_end, last_span
//
// each span of a transaction costs a start-memory read and a load of the output
// register, each opened row one memory write.
// reset clears the sequencer and the output valid; the start memory is not cleared.
// a stalled output holds the sequencer before the next span; input is taken again
// once the open phase ends, even with the last span still waiting in the output.
// Top level: instantiates c2rs_ctrl and c2rs_datapath, uses c2rs_pkg.

module column_to_row_span_converter #(
  parameter int ROWS    = 64,
  parameter int COLUMNS = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [c2rs_pkg::COL_W-1:0]       column,
  input  logic [c2rs_pkg::EDGE_W-1:0]      prev_top,
  input  logic [c2rs_pkg::EDGE_W-1:0]      prev_bottom,
  input  logic [c2rs_pkg::EDGE_W-1:0]      cur_top,
  input  logic [c2rs_pkg::EDGE_W-1:0]      cur_bottom,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [c2rs_pkg::SPAN_ROW_W-1:0]  span_row,
  output logic [c2rs_pkg::COL_W-1:0]       span_start,
  output logic [c2rs_pkg::COL_W-1:0]       span_end,
  output logic                             last_span
);
  import c2rs_pkg::*;

  cmd_t    cmd;
  status_t status;

  c2rs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  c2rs_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .column      (column),
    .prev_top    (prev_top),
    .prev_bottom (prev_bottom),
    .cur_top     (cur_top),
    .cur_bottom  (cur_bottom),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .span_row    (span_row),
    .span_start  (span_start),
    .span_end    (span_end),
    .last_span   (last_span)
  );

endmodule

[rtl/c2rs_datapath.sv]
// c2rs_datapath: edge registers, row start memory and output register.
// Depends on c2rs_pkg; driven by c2rs_ctrl through cmd_t / status_t.

module c2rs_datapath #(
  parameter int ROWS    = 64,
  parameter int COLUMNS = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  c2rs_pkg::cmd_t                   cmd,
  output c2rs_pkg::status_t                status,
  input  logic [c2rs_pkg::COL_W-1:0]       column,
  input  logic [c2rs_pkg::EDGE_W-1:0]      prev_top,
  input  logic [c2rs_pkg::EDGE_W-1:0]      prev_bottom,
  input  logic [c2rs_pkg::EDGE_W-1:0]      cur_top,
  input  logic [c2rs_pkg::EDGE_W-1:0]      cur_bottom,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [c2rs_pkg::SPAN_ROW_W-1:0]  span_row,
  output logic [c2rs_pkg::COL_W-1:0]       span_start,
  output logic [c2rs_pkg::COL_W-1:0]       span_end,
  output logic                             last_span
);
  import c2rs_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  // signed row values run from -1 up to ROWS
  localparam int RW = $clog2(ROWS + 1) + 1;
  localparam logic signed [RW-1:0] ROW_LIMIT = RW'(ROWS);
  localparam logic signed [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
  localparam logic signed [RW-1:0] ONE       = RW'(1);

  logic [COL_W-1:0] mem [ROWS];

  logic signed [RW-1:0] t1, b1, t2, b2;
  logic [COL_W-1:0]     col;
  logic [COL_W-1:0]     end_col;
  logic [COL_W-1:0]     col_c;
  logic [COL_W-1:0]     rd_data;
  logic [AW-1:0]        pend_row;
  logic                 top_more;
  logic                 bot_more;
  logic signed [RW-1:0] row_sel;

  function automatic logic signed [RW-1:0] clamp_row(input logic [EDGE_W-1:0] v);
    if ({1'b0, v} >= (EDGE_W + 1)'(ROWS)) begin
      return ROW_MAX;
    end
    return RW'(v);
  endfunction

  assign col_c = ({1'b0, column} >= (COL_W + 1)'(COLUMNS)) ? COL_W'(COLUMNS - 1) : column;

  assign top_more = (t1 < t2) && (t1 <= b1);
  assign bot_more = (b1 > b2) && (b1 >= t1);
  assign row_sel  = top_more ? t1 : b1;

  assign status.any_close     = top_more || bot_more;
  assign status.open_top_more = (t2 < t1) && (t2 <= b2);
  assign status.open_bot_more = (b2 > b1) && (b2 >= t2);
  assign status.out_free      = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col     <= col_c;
      end_col <= col_c - COL_W'(1);
      if (prev_top == EMPTY_MARK) begin
        t1 <= ROW_LIMIT;
        b1 <= ROW_MAX;
      end else begin
        t1 <= clamp_row(prev_top);
        b1 <= clamp_row(prev_bottom);
      end
      if (cur_top == EMPTY_MARK) begin
        t2 <= ROW_LIMIT;
        b2 <= ROW_MAX;
      end else begin
        t2 <= clamp_row(cur_top);
        b2 <= clamp_row(cur_bottom);
      end
    end else begin
      if (cmd.close_step) begin
        // top rows close first, walking down from the old top
        if (top_more) begin
          t1 <= t1 + ONE;
        end else begin
          b1 <= b1 - ONE;
        end
      end
      if (cmd.open_top) begin
        t2 <= t2 + ONE;
      end
      if (cmd.open_bot) begin
        b2 <= b2 - ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close_step) begin
      rd_data  <= mem[row_sel[AW-1:0]];
      pend_row <= row_sel[AW-1:0];
    end
    if (cmd.open_top) begin
      mem[t2[AW-1:0]] <= col;
    end else if (cmd.open_bot) begin
      mem[b2[AW-1:0]] <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span_row   <= SPAN_ROW_W'(pend_row);
      span_start <= rd_data;
      span_end   <= end_col;
      // edges already advanced, so nothing left to close means last span
      last_span  <= !status.any_close;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[rtl/c2rs_ctrl.sv]
// c2rs_ctrl: sequencer for the close and open phases of one transaction.
// Depends on c2rs_pkg; commands c2rs_datapath.

module c2rs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  c2rs_pkg::status_t   status,
  output c2rs_pkg::cmd_t      cmd
);
  import c2rs_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLOSE_RD = 3'd1;
  localparam logic [2:0] S_EMIT     = 3'd2;
  localparam logic [2:0] S_OPEN_TOP = 3'd3;
  localparam logic [2:0] S_OPEN_BOT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLOSE_RD;
        end
      end
      S_CLOSE_RD: begin
        if (status.any_close) begin
          cmd.close_step = 1'b1;
          state_next     = S_EMIT;
        end else begin
          state_next = S_OPEN_TOP;
        end
      end
      S_EMIT: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_CLOSE_RD;
        end
      end
      S_OPEN_TOP: begin
        if (status.open_top_more) begin
          cmd.open_top = 1'b1;
        end else begin
          state_next = S_OPEN_BOT;
        end
      end
      S_OPEN_BOT: begin
        if (status.open_bot_more) begin
          cmd.open_bot = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/c2rs_checker.sv]
// c2rs_checker: port-level assertions for column_to_row_span_converter,
// bound to the top level below. Depends on c2rs_pkg for field widths.

module c2rs_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [c2rs_pkg::SPAN_ROW_W-1:0]  span_row,
  input  logic [c2rs_pkg::COL_W-1:0]       span_start,
  input  logic [c2rs_pkg::COL_W-1:0]       span_end,
  input  logic                             last_span
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a transaction keeps the block busy for at least the next cycle
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // while spans of a transaction remain, no new transaction may enter
  a_more_spans_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_span |=> in_stall)
    else $error("input accepted before last span of transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(span_row) && $stable(span_start)
      && $stable(span_end) && $stable(last_span))
    else $error("stalled span changed");

endmodule

bind column_to_row_span_converter c2rs_checker u_c2rs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .span_row   (span_row),
  .span_start (span_start),
  .span_end   (span_end),
  .last_span  (last_span)
);
